>>> rtl/bucketized_hash_group_count_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bucketized hash group-count core
// Each macro expects a clock named clock and a synchronous reset named reset.
// ---------------------------------------------------------------------------
`ifndef BUCKETIZED_HASH_GROUP_COUNT_CORE_ASSERT_SVH
`define BUCKETIZED_HASH_GROUP_COUNT_CORE_ASSERT_SVH

// same-cycle implication
`define BHGC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BHGC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/bhgc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bhgc_pkg
// Shared types and constants of the bucketized hash group-count core.
// ---------------------------------------------------------------------------
package bhgc_pkg;

   localparam int BUCKETS_DEF = 64;
   localparam int SLOTS_DEF   = 16;

   localparam int KEY_W    = 32;
   localparam int COUNT_W  = 32;
   localparam int IDX_W    = 10;
   localparam int CSR_W    = 11;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;

   localparam int TABLE_SLOTS_RESET = 1024;

   // divider retires this many quotient bits per cycle
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_STEPS     = KEY_W / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // opcodes
   localparam logic [OP_W-1:0] OP_COUNT  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_COUNTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_KEY_ZERO = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_READ     = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    slot;
      logic [KEY_W-1:0]    key_out;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

   // one slot of a bucket
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [COUNT_W-1:0] count;
   } entry_type;

endpackage

>>> rtl/bucketized_hash_group_count_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bucketized_hash_group_count_core
// Group-count hash table: buckets of key/count slots in one row-wide memory,
// home bucket by key mod bucket count, linear probe with wrap-around.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_type  (opcode, key, entry_index)
//  rsp      out        rsp_valid/rsp_stall  rsp_type  (status, slot, key_out, count)
//  csr      in         csr_we               csr_wdata (table_slots)
//
//  One transaction at a time. Count: the 4-bit-per-cycle hash divider, then for
//  each bucket probed a registered memory read, a compare and an update step.
//  Read: one registered memory read; key zero and out-of-range read skip the memory.
//  Clear: one memory row zeroed per cycle; after reset the same pass runs with
//  req_stall high.
//  A table_slots write holds req_stall in its cycle and the next (bucket count).
//  A result waits in the output register while rsp_stall is high.
// ---------------------------------------------------------------------------
module bucketized_hash_group_count_core
   import bhgc_pkg::*;
#(
   parameter int BUCKETS = BUCKETS_DEF,
   parameter int SLOTS   = SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int TOTAL     = BUCKETS * SLOTS;
   localparam int BW        = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int PW        = $clog2(SLOTS);
   localparam int UW        = $clog2(SLOTS + 1);
   localparam int LW        = $clog2(TOTAL + 1);
   localparam int DVW       = $clog2(((BUCKETS > SLOTS) ? BUCKETS : SLOTS) + 1);
   localparam int SW        = (LW > IDX_W) ? LW : IDX_W;
   localparam int CMPW      = (LW > CSR_W) ? LW : CSR_W;
   localparam int LIM_RESET = (TABLE_SLOTS_RESET < TOTAL) ? TABLE_SLOTS_RESET : TOTAL;
   localparam int NB_RESET  = (LIM_RESET + SLOTS - 1) / SLOTS;

   // reciprocal constants for division by SLOTS, exact over the operand range
   localparam int     IX_SH  = IDX_W + PW;
   localparam int     IXP_W  = 2 * IDX_W + 1;
   localparam longint IX_MUL = ((longint'(1) << IX_SH) + SLOTS - 1) / SLOTS;
   localparam int     NBX_W  = LW + 1;
   localparam int     NB_SH  = NBX_W + PW;
   localparam int     NBP_W  = 2 * NBX_W + 1;
   localparam longint NB_MUL = ((longint'(1) << NB_SH) + SLOTS - 1) / SLOTS;

   typedef entry_type [SLOTS-1:0] row_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SWEEP = 7'b0000010,
      S_DIV   = 7'b0000100,
      S_RD    = 7'b0001000,
      S_CMP   = 7'b0010000,
      S_UPD   = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   // bucket memory, one bucket per row
   row_type bucket_mem [BUCKETS];

   state_type        state_ff, state_in;
   logic             clr_rsp_ff, clr_rsp_in;
   logic             is_read_ff, is_read_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [BW-1:0]    bucket_ff, bucket_in;
   logic [LW-1:0]    base_ff, base_in;
   logic [BW-1:0]    probe_ff, probe_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [UW-1:0]    usable_ff, usable_in;
   logic             hit_ff, hit_in;
   logic             free_ff, free_in;
   logic [PW-1:0]    hit_pos_ff, hit_pos_in;
   logic [BW-1:0]    sweep_ff, sweep_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]    lim_ff, lim_in;
   logic [DVW-1:0]   nb_ff, nb_in;
   logic             nb_pend_ff, nb_pend_in;
   row_type          rd_row_ff;

   logic             req_acc;
   logic             out_free;
   logic             mem_we;
   logic [BW-1:0]    mem_waddr;
   row_type          mem_wdata;
   logic             mem_re;
   logic             div_go;
   logic             div_start;
   logic [KEY_W-1:0] div_dividend;
   logic [DVW-1:0]   div_divisor;
   logic             div_done;
   logic [DVW-1:0]   div_rem;
   logic [CMPW-1:0]  csr_ext;
   logic [LW-1:0]    lim_clamp;
   logic [LW-1:0]    room;
   logic             c_hit, c_free;
   logic [PW-1:0]    c_hit_pos, c_free_pos;
   logic [SW-1:0]    slot_sum;
   logic [COUNT_W-1:0] old_count, new_count;
   entry_type        upd_entry;
   logic [IXP_W-1:0] ix_prod;
   logic [IDX_W-1:0] ix_quo;
   logic [IDX_W-1:0] ix_rem;
   logic [NBX_W-1:0] nb_num;
   logic [NBP_W-1:0] nb_prod;

   assign req_stall = (state_ff != S_IDLE) || nb_pend_ff || csr_we;
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // hash divider: key mod bucket count
   assign div_start    = div_go;
   assign div_dividend = req_data.key;
   assign div_divisor  = nb_ff;

   bhgc_divider #(
      .DIVISOR_W (DVW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   // read index split into bucket row and position
   always_comb begin
      ix_prod = IXP_W'(req_data.entry_index) * IXP_W'(IX_MUL);
      ix_quo  = IDX_W'(ix_prod >> IX_SH);
      ix_rem  = req_data.entry_index - IDX_W'(ix_quo * IDX_W'(SLOTS));
   end

   // slot limit clamp: zero acts as one, capped at the table size
   always_comb begin
      csr_ext = CMPW'(csr_wdata);
      if (csr_ext == '0) begin
         lim_clamp = LW'(1);
      end else if (csr_ext > CMPW'(TOTAL)) begin
         lim_clamp = LW'(TOTAL);
      end else begin
         lim_clamp = LW'(csr_ext);
      end
   end

   // bucket count: ceiling of the slot limit over SLOTS, reloaded after a write
   assign nb_num  = NBX_W'(lim_ff) + NBX_W'(SLOTS - 1);
   assign nb_prod = NBP_W'(nb_num) * NBP_W'(NB_MUL);

   always_comb begin
      lim_in     = csr_we ? lim_clamp : lim_ff;
      nb_pend_in = csr_we;
      nb_in      = nb_pend_ff ? DVW'(nb_prod >> NB_SH) : nb_ff;
   end

   // usable slots left in the current bucket
   assign room = lim_ff - base_ff;

   // lowest matching and lowest free usable slot of the fetched bucket
   always_comb begin
      c_hit      = 1'b0;
      c_free     = 1'b0;
      c_hit_pos  = '0;
      c_free_pos = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (UW'(s) < usable_ff) begin
            if (rd_row_ff[s].key == key_ff) begin
               c_hit     = 1'b1;
               c_hit_pos = PW'(s);
            end
            if (rd_row_ff[s].key == '0) begin
               c_free     = 1'b1;
               c_free_pos = PW'(s);
            end
         end
      end
   end

   // update datapath
   assign slot_sum  = SW'(base_ff) + SW'(hit_pos_ff);
   assign old_count = rd_row_ff[hit_pos_ff].count;
   assign new_count = (old_count == '1) ? old_count : (old_count + COUNT_W'(1));

   always_comb begin
      upd_entry.key   = key_ff;
      upd_entry.count = hit_ff ? new_count : COUNT_W'(1);
   end

   // main sequencer
   always_comb begin
      state_in     = state_ff;
      clr_rsp_in   = clr_rsp_ff;
      is_read_in   = is_read_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      bucket_in    = bucket_ff;
      base_in      = base_ff;
      probe_in     = probe_ff;
      pos_in       = pos_ff;
      usable_in    = usable_ff;
      hit_in       = hit_ff;
      free_in      = free_ff;
      hit_pos_in   = hit_pos_ff;
      sweep_in     = sweep_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;
      mem_we       = 1'b0;
      mem_waddr    = bucket_ff;
      mem_wdata    = rd_row_ff;
      mem_re       = 1'b0;
      div_go       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               key_in = req_data.key;
               idx_in = req_data.entry_index;
               unique case (req_data.opcode) inside
                  OP_COUNT: begin
                     is_read_in = 1'b0;
                     if (req_data.key == '0) begin
                        res_in   = '{status: STATUS_KEY_ZERO, slot: '0, key_out: '0,
                                     count: '0};
                        state_in = S_RESP;
                     end else begin
                        div_go   = 1'b1;
                        state_in = S_DIV;
                     end
                  end
                  OP_CLEAR: begin
                     sweep_in   = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_SWEEP;
                  end
                  OP_READ, OP_UNUSED: begin
                     // read, and the spare code acting as read
                     is_read_in = 1'b1;
                     if (SW'(req_data.entry_index) >= SW'(TOTAL)) begin
                        res_in   = '{status: STATUS_READ, slot: req_data.entry_index,
                                     key_out: '0, count: '0};
                        state_in = S_RESP;
                     end else begin
                        bucket_in = BW'(ix_quo);
                        pos_in    = PW'(ix_rem);
                        state_in  = S_RD;
                     end
                  end
               endcase
            end
         end

         S_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            if (sweep_ff == BW'(BUCKETS - 1)) begin
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  res_in   = '{status: STATUS_CLEARED, slot: '0, key_out: '0, count: '0};
                  state_in = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + BW'(1);
            end
         end

         S_DIV: begin
            if (div_done) begin
               bucket_in = BW'(div_rem);
               base_in   = LW'(LW'(div_rem) * LW'(SLOTS));
               probe_in  = '0;
               state_in  = S_RD;
            end
         end

         S_RD: begin
            mem_re    = 1'b1;
            usable_in = (room >= LW'(SLOTS)) ? UW'(SLOTS) : UW'(room);
            state_in  = S_CMP;
         end

         S_CMP: begin
            if (is_read_ff) begin
               res_in   = '{status: STATUS_READ, slot: idx_ff,
                            key_out: rd_row_ff[pos_ff].key,
                            count: rd_row_ff[pos_ff].count};
               state_in = S_RESP;
            end else begin
               hit_in     = c_hit;
               free_in    = c_free;
               hit_pos_in = c_hit ? c_hit_pos : c_free_pos;
               state_in   = S_UPD;
            end
         end

         S_UPD: begin
            if (hit_ff || free_ff) begin
               mem_we                = 1'b1;
               mem_wdata[hit_pos_ff] = upd_entry;
               res_in   = '{status: hit_ff ? STATUS_COUNTED : STATUS_INSERTED,
                            slot: slot_sum[IDX_W-1:0], key_out: key_ff,
                            count: upd_entry.count};
               state_in = S_RESP;
            end else if (DVW'(probe_ff) == (nb_ff - DVW'(1))) begin
               res_in   = '{status: STATUS_FULL, slot: '0, key_out: '0, count: '0};
               state_in = S_RESP;
            end else begin
               // next bucket, wrapping to bucket zero
               probe_in = probe_ff + BW'(1);
               if (DVW'(bucket_ff) == (nb_ff - DVW'(1))) begin
                  bucket_in = '0;
                  base_in   = '0;
               end else begin
                  bucket_in = bucket_ff + BW'(1);
                  base_in   = base_ff + LW'(SLOTS);
               end
               state_in = S_RD;
            end
         end

         S_RESP: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lim_ff       <= LW'(LIM_RESET);
         nb_ff        <= DVW'(NB_RESET);
         nb_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         lim_ff       <= lim_in;
         nb_ff        <= nb_in;
         nb_pend_ff   <= nb_pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      is_read_ff  <= is_read_in;
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      bucket_ff   <= bucket_in;
      base_ff     <= base_in;
      probe_ff    <= probe_in;
      pos_ff      <= pos_in;
      usable_ff   <= usable_in;
      hit_ff      <= hit_in;
      free_ff     <= free_in;
      hit_pos_ff  <= hit_pos_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // bucket memory ports, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bucket_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_row_ff <= bucket_mem[bucket_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "bucketized_hash_group_count_core_assert.svh"

   `BHGC_ASSERT_IMP(a_mem_write_owner, mem_we, (state_ff == S_UPD) || (state_ff == S_SWEEP), "stray write")
   `BHGC_ASSERT_IMP(a_div_done_owner, div_done, state_ff == S_DIV, "divider result with no owner")
   `BHGC_ASSERT_IMP(a_rsp_from_resp, $rose(rsp_valid_ff), $past(state_ff == S_RESP), "stray result")
   `BHGC_ASSERT_IMP(a_slot_usable, (state_ff == S_UPD) && (hit_ff || free_ff), UW'(hit_pos_ff) < usable_ff, "bad slot")

endmodule

>>> rtl/bhgc_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bhgc_divider
// Restoring divider for a 32-bit dividend by a narrow divisor, a few
// quotient bits per cycle. Gives the remainder.
// ---------------------------------------------------------------------------
module bhgc_divider
   import bhgc_pkg::*;
#(
   parameter int DIVISOR_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [KEY_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [DIVISOR_W-1:0] remainder
);

   logic                     busy_ff;
   logic                     done_ff;
   logic [DIV_CNT_W-1:0]     cnt_ff;
   logic [KEY_W-1:0]         quo_ff;
   logic [DIVISOR_W-1:0]     rem_ff;
   logic [DIVISOR_W-1:0]     div_ff;

   logic [DIVISOR_W:0]       trial;
   logic [DIVISOR_W-1:0]     rem_step;
   logic [DIV_STEP_BITS-1:0] quo_bits;
   logic [KEY_W-1:0]         quo_step;

   // one group of restoring steps; dividend bits shift out as quotient bits shift in
   always_comb begin
      rem_step = rem_ff;
      quo_bits = '0;
      trial    = '0;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         trial = {rem_step, quo_ff[KEY_W-1-i]};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
            quo_bits[DIV_STEP_BITS-1-i] = 1'b1;
         end
         rem_step = trial[DIVISOR_W-1:0];
      end
      quo_step = {quo_ff[KEY_W-DIV_STEP_BITS-1:0], quo_bits};
   end

   // control; a start restarts any run in progress
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_step;
         rem_ff <= rem_step;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

`include "bucketized_hash_group_count_core_assert.svh"

   `BHGC_ASSERT_IMP(a_rem_below_divisor, done_ff, rem_ff < div_ff, "remainder not below divisor")
   `BHGC_ASSERT_NXT(a_start_busy, start, busy_ff, "divider not busy after start")
   `BHGC_ASSERT_IMP(a_done_not_busy, done_ff, !busy_ff, "divider done while busy")

endmodule
